### design/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types and constants of the ASCII integer parser: the word formats
// of the input and result channels, the configuration and parser state
// records, and the code values for bases, phases and status.
// ----------------------------------------------------------------------------
package aip_pkg;

  localparam int ACC_BITS   = 64;
  localparam int WIDTH_BITS = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = WIDTH_BITS;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_RESULT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_SIZE   = 2'd3;

  // Base codes.
  localparam logic [1:0] BASE_AUTO = 2'd0;
  localparam logic [1:0] BASE_OCT  = 2'd1;
  localparam logic [1:0] BASE_DEC  = 2'd2;
  localparam logic [1:0] BASE_HEX  = 2'd3;

  // Destination size codes.
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  // Parser phases.
  localparam logic [1:0] PH_SKIP    = 2'd0;
  localparam logic [1:0] PH_PREFIX0 = 2'd1;
  localparam logic [1:0] PH_PREFIXX = 2'd2;
  localparam logic [1:0] PH_DIGITS  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_NODIG  = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // Character codes.
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Saturation thresholds of the accumulator for each radix.
  localparam logic [ACC_BITS-1:0] ACC_MAX    = '1;
  localparam logic [ACC_BITS-1:0] CUT_OCT    = ACC_MAX / ACC_BITS'(8);
  localparam logic [ACC_BITS-1:0] CUT_DEC    = ACC_MAX / ACC_BITS'(10);
  localparam logic [ACC_BITS-1:0] CUT_HEX    = ACC_MAX / ACC_BITS'(16);
  localparam logic [3:0]          CUTLIM_OCT = 4'(ACC_MAX % ACC_BITS'(8));
  localparam logic [3:0]          CUTLIM_DEC = 4'(ACC_MAX % ACC_BITS'(10));
  localparam logic [3:0]          CUTLIM_HEX = 4'(ACC_MAX % ACC_BITS'(16));

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } aip_in_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic        char_consumed;
  } aip_out_t;

  typedef struct packed {
    logic [1:0]            base_mode;
    logic [WIDTH_BITS-1:0] width_limit;
    logic                  signed_result;
    logic [1:0]            result_size;
  } aip_cfg_t;

  typedef struct packed {
    logic [1:0]            phase;
    logic [ACC_BITS-1:0]   magnitude;
    logic                  is_negative;
    logic                  saw_digit;
    logic                  overflowed;
    logic [WIDTH_BITS-1:0] chars_left;
    logic [1:0]            active_base;
  } aip_state_t;

endpackage

### design/aip_cfg.sv
// ----------------------------------------------------------------------------
// aip_cfg
// Configuration register file of the parser, written over its own
// valid/ready channel.
// ----------------------------------------------------------------------------
module aip_cfg import aip_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output aip_cfg_t              cfg_o
);

  aip_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_mode     <= BASE_DEC;
      cfg_q.width_limit   <= '0;
      cfg_q.signed_result <= 1'b1;
      cfg_q.result_size   <= SIZE_32;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BASE_MODE:     cfg_q.base_mode     <= cfg_data_i[1:0];
        REG_WIDTH_LIMIT:   cfg_q.width_limit   <= cfg_data_i[WIDTH_BITS-1:0];
        REG_SIGNED_RESULT: cfg_q.signed_result <= cfg_data_i[0];
        REG_RESULT_SIZE:   cfg_q.result_size   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

endmodule

### design/aip_step.sv
// ----------------------------------------------------------------------------
// aip_step
// One character step of the parser: from the current state, configuration
// and character it forms the next state and, when a number ends, the
// clamped result word, or the empty word at the end of an empty input.
// ----------------------------------------------------------------------------
module aip_step import aip_pkg::*; (
  input  aip_cfg_t   cfg_i,
  input  aip_state_t st_i,
  input  aip_in_t    in_i,
  output aip_state_t st_o,
  output logic       emit_o,
  output aip_out_t   res_o
);

  aip_state_t          s;
  logic                go;
  logic                fin;
  logic                fin_cons;
  logic                empty_end;
  logic                is_ws;
  logic                dig_ok;
  logic [3:0]          dig;
  logic [4:0]          radix;
  logic [ACC_BITS-1:0] cutoff;
  logic [3:0]          cutlim;
  logic [ACC_BITS-1:0] scaled;
  logic [63:0]         mag64;
  logic [63:0]         ulim;
  logic [63:0]         plim;
  logic [63:0]         nlim;
  logic [63:0]         slim;
  logic [63:0]         value;
  logic [1:0]          status;

  assign is_ws = (in_i.ch == CH_SPACE) || (in_i.ch >= CH_TAB && in_i.ch <= CH_CR);

  always_comb begin
    dig    = 4'd0;
    dig_ok = 1'b0;
    if (in_i.ch >= CH_0 && in_i.ch <= CH_9) begin
      dig    = 4'(in_i.ch - CH_0);
      dig_ok = 1'b1;
    end else if (in_i.ch >= CH_LA && in_i.ch <= CH_LF) begin
      dig    = 4'(in_i.ch - CH_LA + 8'd10);
      dig_ok = 1'b1;
    end else if (in_i.ch >= CH_UA && in_i.ch <= CH_UF) begin
      dig    = 4'(in_i.ch - CH_UA + 8'd10);
      dig_ok = 1'b1;
    end
  end

  // Character walk through the phases. A finish request is collected in fin
  // and the clamp below works on the state as it stands at that point.
  always_comb begin
    s         = st_i;
    go        = 1'b0;
    fin       = 1'b0;
    fin_cons  = 1'b0;
    empty_end = 1'b0;
    radix     = 5'd10;
    cutoff    = CUT_DEC;
    cutlim    = CUTLIM_DEC;
    scaled    = '0;
    if (st_i.phase == PH_SKIP) begin
      if (in_i.end_of_input) begin
        empty_end = 1'b1;
      end else if (!is_ws) begin
        s.magnitude   = '0;
        s.is_negative = 1'b0;
        s.saw_digit   = 1'b0;
        s.overflowed  = 1'b0;
        s.chars_left  = cfg_i.width_limit;
        s.active_base = cfg_i.base_mode;
        s.phase       = (cfg_i.base_mode == BASE_AUTO || cfg_i.base_mode == BASE_HEX) ?
                        PH_PREFIX0 : PH_DIGITS;
        if (in_i.ch == CH_PLUS || in_i.ch == CH_MINUS) begin
          s.is_negative = (in_i.ch == CH_MINUS);
          if (cfg_i.width_limit != '0 && s.chars_left != '0) s.chars_left = s.chars_left - 1'b1;
          if (cfg_i.width_limit != '0 && s.chars_left == '0) begin
            fin      = 1'b1;
            fin_cons = 1'b1;
          end
        end else begin
          go = 1'b1;
        end
      end
    end else if (in_i.end_of_input ||
                 (cfg_i.width_limit != '0 && st_i.chars_left == '0)) begin
      fin = 1'b1;
    end else begin
      go = 1'b1;
    end

    if (go && s.phase == PH_PREFIX0) begin
      if (in_i.ch == CH_0) begin
        go = 1'b0;
        if (cfg_i.width_limit != '0 && s.chars_left != '0) s.chars_left = s.chars_left - 1'b1;
        s.phase = PH_PREFIXX;
        if (cfg_i.width_limit != '0 && s.chars_left == '0) begin
          fin      = 1'b1;
          fin_cons = 1'b1;
        end
      end else begin
        s.active_base = (s.active_base == BASE_AUTO) ? BASE_DEC : BASE_HEX;
        s.phase       = PH_DIGITS;
      end
    end

    if (go && s.phase == PH_PREFIXX) begin
      if (in_i.ch == CH_LX || in_i.ch == CH_UX) begin
        go = 1'b0;
        if (cfg_i.width_limit != '0 && s.chars_left != '0) s.chars_left = s.chars_left - 1'b1;
        s.active_base = BASE_HEX;
        s.phase       = PH_DIGITS;
        if (cfg_i.width_limit != '0 && s.chars_left == '0) begin
          fin      = 1'b1;
          fin_cons = 1'b1;
        end
      end else begin
        // The leading 0 already counts as a digit.
        s.saw_digit   = 1'b1;
        s.active_base = (s.active_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
        s.phase       = PH_DIGITS;
      end
    end

    if (go) begin
      if (s.active_base == BASE_AUTO) s.active_base = BASE_DEC;
      unique case (s.active_base)
        BASE_OCT: begin
          radix  = 5'd8;
          cutoff = CUT_OCT;
          cutlim = CUTLIM_OCT;
          scaled = s.magnitude << 3;
        end
        BASE_HEX: begin
          radix  = 5'd16;
          cutoff = CUT_HEX;
          cutlim = CUTLIM_HEX;
          scaled = s.magnitude << 4;
        end
        default: begin
          radix  = 5'd10;
          cutoff = CUT_DEC;
          cutlim = CUTLIM_DEC;
          scaled = (s.magnitude << 3) + (s.magnitude << 1);
        end
      endcase
      if (!dig_ok || {1'b0, dig} >= radix) begin
        fin = 1'b1;
      end else begin
        if (cfg_i.width_limit != '0 && s.chars_left != '0) s.chars_left = s.chars_left - 1'b1;
        s.saw_digit = 1'b1;
        if (!s.overflowed) begin
          if (s.magnitude > cutoff || (s.magnitude == cutoff && dig > cutlim)) begin
            s.magnitude  = ACC_MAX;
            s.overflowed = 1'b1;
          end else begin
            s.magnitude = scaled + ACC_BITS'(dig);
          end
        end
        if (cfg_i.width_limit != '0 && s.chars_left == '0) begin
          fin      = 1'b1;
          fin_cons = 1'b1;
        end
      end
    end
  end

  // Clamp of the finished magnitude to the destination range.
  always_comb begin
    mag64 = 64'(s.magnitude);
    case (cfg_i.result_size)
      SIZE_8:  ulim = 64'h0000_0000_0000_00FF;
      SIZE_16: ulim = 64'h0000_0000_0000_FFFF;
      SIZE_32: ulim = 64'h0000_0000_FFFF_FFFF;
      default: ulim = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    plim   = ulim >> 1;
    nlim   = plim + 64'd1;
    slim   = s.is_negative ? nlim : plim;
    value  = '0;
    status = ST_OK;
    if (!(s.saw_digit || s.phase == PH_PREFIXX)) begin
      status = ST_NODIG;
    end else if (cfg_i.signed_result) begin
      if (s.overflowed || mag64 > slim) begin
        status = ST_RANGE;
        value  = s.is_negative ? (64'd0 - nlim) : plim;
      end else begin
        value  = s.is_negative ? (64'd0 - mag64) : mag64;
      end
    end else begin
      if (s.overflowed || mag64 > ulim) begin
        status = ST_RANGE;
        value  = ulim;
      end else begin
        value  = s.is_negative ? ((64'd0 - mag64) & ulim) : mag64;
      end
    end
  end

  always_comb begin
    st_o   = s;
    emit_o = fin || empty_end;
    res_o  = '{value: value, status: status, char_consumed: fin_cons};
    if (empty_end) begin
      res_o = '{value: 64'd0, status: ST_EMPTY, char_consumed: 1'b0};
    end
    if (fin) begin
      st_o = '{phase: PH_SKIP, magnitude: '0, is_negative: 1'b0, saw_digit: 1'b0,
               overflowed: 1'b0, chars_left: '0, active_base: BASE_AUTO};
    end
  end

endmodule

### design/ascii_integer_parser_core.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser_core
// Streaming text-to-integer parser with scanf-style integer conversion.
// ----------------------------------------------------------------------------
// One character word is taken per clock cycle. A word is held in an input
// register and stepped through the parser once the output has room. When it
// ends a number, its result word is loaded into an output register at that
// step, so a result passes the input and then the output register. A new
// word may enter in every cycle. The only thing that slows the stream is a
// result word left waiting in the output register. It holds back the step of
// the held word, whether or not that word ends a number. Configuration writes
// are taken in any cycle and act from the next step on, so they should only
// be issued while no character word is held in the block. A number that is
// already open keeps its base, but it sees a new width limit, sign mode or
// size at once.
module ascii_integer_parser_core import aip_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  aip_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output aip_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  aip_cfg_t   cfg;
  aip_state_t st_q;
  aip_state_t st_d;
  aip_in_t    in_q;
  logic       in_valid_q;
  aip_out_t   out_q;
  logic       out_valid_q;
  aip_out_t   res;
  logic       emit;
  logic       step;

  aip_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  aip_step u_step (
    .cfg_i  (cfg),
    .st_i   (st_q),
    .in_i   (in_q),
    .st_o   (st_d),
    .emit_o (emit),
    .res_o  (res)
  );

  // The held word is stepped once the output register has room for a result.
  assign step        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_SKIP, magnitude: '0, is_negative: 1'b0, saw_digit: 1'b0,
                overflowed: 1'b0, chars_left: '0, active_base: BASE_AUTO};
    end else if (step) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_q <= res;
    end
  end

endmodule

### tb/sv/tb_ascii_integer_parser_core.sv
// ----------------------------------------------------------------------------
// tb_ascii_integer_parser_core
// Self-checking bench for the streaming ASCII integer parser. A short table
// of directed words (prefixes, signs, clamps, empty input and a width change
// in the middle of a number) is followed by random numbers and noise under
// many register settings. A character-level model of the parser predicts the
// results the table leaves unset, matched in order as they leave the block.
// ----------------------------------------------------------------------------
module tb_ascii_integer_parser_core;
  import aip_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_ITEMS   = 1650;
  localparam int NUM_SETTINGS = 15;
  localparam int SETTLE       = 4;
  localparam logic [63:0] ALL_ONES = '1;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [1:0] reg_idx;
    logic [7:0] reg_data;
    aip_in_t    word;
    logic       typed;
    aip_out_t   want;
  } step_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  aip_in_t    in_word = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  aip_out_t   out_word;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // Model copy of the registers and of the parser state.
  aip_cfg_t   cfg_m;
  aip_state_t prs;

  aip_out_t   pending_results[$];
  aip_out_t   head_result;
  step_row_t  plan[$];
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         words_done = 0;
  int         fail_count = 0;
  int         cycle_count = 0;

  ascii_integer_parser_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------
  function automatic bit is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int radix_of(logic [1:0] code);
    case (code)
      BASE_OCT: return 8;
      BASE_HEX: return 16;
      default:  return 10;
    endcase
  endfunction

  function automatic int digit_value(logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function automatic void take_char();
    if (cfg_m.width_limit != 0 && prs.chars_left != 0)
      prs.chars_left = prs.chars_left - 1'b1;
  endfunction

  // The width limit is read live, so a limit set mid-number counts here.
  function automatic bit width_spent();
    return (cfg_m.width_limit != 0) && (prs.chars_left == 0);
  endfunction

  function automatic void accumulate(int d, int radix);
    logic [63:0] cut;
    logic [63:0] lim;
    cut = ALL_ONES / 64'(radix);
    lim = ALL_ONES % 64'(radix);
    prs.saw_digit = 1'b1;
    if (prs.overflowed) return;
    if (prs.magnitude > cut || (prs.magnitude == cut && 64'(d) > lim)) begin
      prs.magnitude  = ALL_ONES;
      prs.overflowed = 1'b1;
    end else begin
      prs.magnitude = prs.magnitude * 64'(radix) + 64'(d);
    end
  endfunction

  function automatic aip_out_t close_number(logic consumed);
    aip_out_t    r;
    logic [63:0] ulim;
    logic [63:0] plim;
    logic [63:0] nlim;
    int          bits;
    bits = 8 << cfg_m.result_size;
    // A bare leading zero is the digit zero.
    if (prs.phase == PH_PREFIXX) prs.saw_digit = 1'b1;
    ulim = ALL_ONES >> (64 - bits);
    plim = ulim >> 1;
    nlim = plim + 64'd1;
    r.value         = '0;
    r.status        = ST_OK;
    r.char_consumed = consumed;
    if (!prs.saw_digit) begin
      r.status = ST_NODIG;
    end else if (cfg_m.signed_result) begin
      if (prs.overflowed || prs.magnitude > (prs.is_negative ? nlim : plim)) begin
        r.status = ST_RANGE;
        r.value  = prs.is_negative ? (64'd0 - nlim) : plim;
      end else begin
        r.value = prs.is_negative ? (64'd0 - prs.magnitude) : prs.magnitude;
      end
    end else begin
      if (prs.overflowed || prs.magnitude > ulim) begin
        r.status = ST_RANGE;
        r.value  = ulim;
      end else begin
        r.value = prs.is_negative ? ((64'd0 - prs.magnitude) & ulim) : prs.magnitude;
      end
    end
    prs       = '0;
    prs.phase = PH_SKIP;
    return r;
  endfunction

  function automatic bit parse_step(input aip_in_t w, output aip_out_t r);
    int         d;
    logic [7:0] c;
    c = w.ch;
    r = '0;
    if (prs.phase == PH_SKIP) begin
      if (w.end_of_input) begin
        r.status = ST_EMPTY;
        return 1'b1;
      end
      if (is_space(c)) return 1'b0;
      prs.magnitude   = '0;
      prs.is_negative = 1'b0;
      prs.saw_digit   = 1'b0;
      prs.overflowed  = 1'b0;
      prs.chars_left  = cfg_m.width_limit;
      prs.active_base = cfg_m.base_mode;
      prs.phase = (cfg_m.base_mode == BASE_AUTO || cfg_m.base_mode == BASE_HEX) ?
                  PH_PREFIX0 : PH_DIGITS;
      if (c == CH_PLUS || c == CH_MINUS) begin
        prs.is_negative = (c == CH_MINUS);
        take_char();
        if (width_spent()) begin
          r = close_number(1'b1);
          return 1'b1;
        end
        return 1'b0;
      end
    end else if (w.end_of_input || width_spent()) begin
      r = close_number(1'b0);
      return 1'b1;
    end

    if (prs.phase == PH_PREFIX0) begin
      if (c == CH_0) begin
        take_char();
        prs.phase = PH_PREFIXX;
        if (width_spent()) begin
          r = close_number(1'b1);
          return 1'b1;
        end
        return 1'b0;
      end
      prs.active_base = (prs.active_base == BASE_AUTO) ? BASE_DEC : BASE_HEX;
      prs.phase = PH_DIGITS;
    end
    if (prs.phase == PH_PREFIXX) begin
      if (c == CH_LX || c == CH_UX) begin
        take_char();
        prs.active_base = BASE_HEX;
        prs.phase = PH_DIGITS;
        if (width_spent()) begin
          r = close_number(1'b1);
          return 1'b1;
        end
        return 1'b0;
      end
      prs.saw_digit   = 1'b1;
      prs.active_base = (prs.active_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
      prs.phase = PH_DIGITS;
    end
    if (prs.active_base == BASE_AUTO) prs.active_base = BASE_DEC;
    d = digit_value(c);
    if (d < 0 || d >= radix_of(prs.active_base)) begin
      r = close_number(1'b0);
      return 1'b1;
    end
    take_char();
    accumulate(d, radix_of(prs.active_base));
    if (width_spent()) begin
      r = close_number(1'b1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------
  function automatic step_row_t word_row(logic [7:0] c, logic eoi = 1'b0);
    step_row_t row;
    row = '0;
    row.kind = ROW_WORD;
    row.word.ch = c;
    row.word.end_of_input = eoi;
    return row;
  endfunction

  function automatic step_row_t check_row(logic [7:0] c, logic eoi, logic [63:0] v,
                                          logic [1:0] st, logic cons);
    step_row_t row;
    row = word_row(c, eoi);
    row.typed = 1'b1;
    row.want.value = v;
    row.want.status = st;
    row.want.char_consumed = cons;
    return row;
  endfunction

  function automatic step_row_t reg_row(logic [1:0] idx, logic [7:0] data);
    step_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_data = data;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] digit_char(int d);
    if (d < 10) return CH_0 + 8'(d);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 10);
  endfunction

  function automatic logic [7:0] space_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
  endfunction

  // Sends one character word; valid stays high from word to word unless a
  // gap is taken, so it is never dropped and raised in the same step.
  task automatic send_word(aip_in_t w, logic typed = 1'b0, aip_out_t want = '0);
    aip_out_t pred;
    bit       got;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = parse_step(w, pred);
    if (typed) pending_results.push_back(want);
    else if (got) pending_results.push_back(pred);
    words_done++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BASE_MODE:     cfg_m.base_mode     = data[1:0];
      REG_WIDTH_LIMIT:   cfg_m.width_limit   = data;
      REG_SIGNED_RESULT: cfg_m.signed_result = data[0];
      REG_RESULT_SIZE:   cfg_m.result_size   = data[1:0];
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Holds the sender until every predicted result has left the block, then
  // lets words that produce no result finish their pass through it.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One number in the current base, with random content, at times broken by a digit outside the base.
  task automatic send_number();
    int          radix;
    int          n;
    int          b;
    logic [63:0] v;
    logic [7:0]  digits[$];
    aip_in_t     w;
    w = '0;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) begin
      w.ch = space_char();
      send_word(w);
    end
    case ($urandom_range(0, 3))
      0: begin w.ch = CH_PLUS;  send_word(w); end
      1: begin w.ch = CH_MINUS; send_word(w); end
      default: ;
    endcase
    radix = radix_of(cfg_m.base_mode);
    if (cfg_m.base_mode == BASE_AUTO) begin
      case ($urandom_range(0, 2))
        0: radix = 10;
        1: begin radix = 8; w.ch = CH_0; send_word(w); end
        default: begin
          radix = 16;
          w.ch = CH_0;
          send_word(w);
          w.ch = $urandom_range(0, 1) ? CH_LX : CH_UX;
          send_word(w);
        end
      endcase
    end else if (cfg_m.base_mode == BASE_HEX && $urandom_range(0, 1)) begin
      w.ch = CH_0;
      send_word(w);
      w.ch = $urandom_range(0, 1) ? CH_LX : CH_UX;
      send_word(w);
    end

    if ($urandom_range(0, 2) == 0) begin
      // A value next to a signed or unsigned limit of some size.
      b = 8 << $urandom_range(0, 3);
      case ($urandom_range(0, 2))
        0: v = (64'd1 << b) - 64'd1;
        1: v = 64'd1 << (b - 1);
        default: v = (64'd1 << (b - 1)) - 64'd1;
      endcase
      v = v + 64'($urandom_range(0, 2)) - 64'd1;
      do begin
        digits.push_front(digit_char(int'(v % 64'(radix))));
        v = v / 64'(radix);
      end while (v != 0);
    end else begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 5);
      repeat (n) digits.push_back(digit_char($urandom_range(0, radix - 1)));
    end
    if (radix < 16 && $urandom_range(0, 15) == 0)
      digits.insert($urandom_range(0, digits.size() - 1),
                    digit_char($urandom_range(radix, 15)));
    foreach (digits[i]) begin
      w.ch = digits[i];
      send_word(w);
    end

    case ($urandom_range(0, 4))
      0: begin w.ch = space_char(); send_word(w); end
      1: begin w.ch = 8'($urandom_range(0, 255)); w.end_of_input = 1'b1; send_word(w); end
      2: begin w.ch = 8'($urandom_range(0, 255)); send_word(w); end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result word: value=%h status=%0d consumed=%0d",
                   out_word.value, out_word.status, out_word.char_consumed);
      end else begin
        head_result = pending_results.pop_front();
        if (out_word.value !== head_result.value ||
            out_word.status !== head_result.status ||
            out_word.char_consumed !== head_result.char_consumed) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                     head_result.value, head_result.status, head_result.char_consumed,
                     out_word.value, out_word.status, out_word.char_consumed);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    aip_in_t    w;
    int         target;
    logic [1:0] bm;
    logic [7:0] wl;
    logic       sg;
    logic [1:0] sz;

    cfg_m.base_mode     = BASE_DEC;
    cfg_m.width_limit   = '0;
    cfg_m.signed_result = 1'b1;
    cfg_m.result_size   = SIZE_32;
    prs       = '0;
    prs.phase = PH_SKIP;

    // Reset values: decimal, unlimited width, signed, 32 bits.
    plan.push_back(check_row(8'h00, 1'b1, 64'd0, ST_EMPTY, 1'b0));
    plan.push_back(word_row(CH_SPACE));
    plan.push_back(word_row(CH_TAB));
    plan.push_back(word_row(CH_MINUS));
    plan.push_back(word_row("7"));
    plan.push_back(check_row(8'h00, 1'b0, 64'hFFFF_FFFF_FFFF_FFF9, ST_OK, 1'b0));
    plan.push_back(word_row(CH_PLUS));
    plan.push_back(check_row(8'hFF, 1'b0, 64'd0, ST_NODIG, 1'b0));
    // A width limit set while a number is open ends it at the next word.
    plan.push_back(word_row("1"));
    plan.push_back(word_row("2"));
    plan.push_back(reg_row(REG_WIDTH_LIMIT, 8'd3));
    plan.push_back(word_row("3"));
    plan.push_back(reg_row(REG_BASE_MODE, 8'(BASE_AUTO)));
    plan.push_back(reg_row(REG_WIDTH_LIMIT, 8'd0));
    plan.push_back(reg_row(REG_SIGNED_RESULT, 8'd0));
    plan.push_back(reg_row(REG_RESULT_SIZE, 8'(SIZE_64)));
    plan.push_back(word_row(CH_0));
    plan.push_back(word_row(CH_LX));
    plan.push_back(word_row("f"));
    plan.push_back(word_row(8'h00, 1'b1));
    plan.push_back(word_row(CH_0));
    plan.push_back(check_row(8'h00, 1'b1, 64'd0, ST_OK, 1'b0));
    plan.push_back(word_row(CH_0));
    plan.push_back(word_row(CH_UX));
    plan.push_back(check_row("g", 1'b0, 64'd0, ST_NODIG, 1'b0));
    // Hex, unsigned 8 bits, two characters: a negative wraps.
    plan.push_back(reg_row(REG_BASE_MODE, 8'(BASE_HEX)));
    plan.push_back(reg_row(REG_RESULT_SIZE, 8'(SIZE_8)));
    plan.push_back(reg_row(REG_WIDTH_LIMIT, 8'd2));
    plan.push_back(word_row(CH_MINUS));
    plan.push_back(word_row("F"));
    plan.push_back(reg_row(REG_WIDTH_LIMIT, 8'd0));
    plan.push_back(word_row("1"));
    plan.push_back(word_row("F"));
    plan.push_back(word_row("F"));
    plan.push_back(check_row(8'h00, 1'b1, 64'h0000_0000_0000_00FF, ST_RANGE, 1'b0));
    plan.push_back(reg_row(REG_BASE_MODE, 8'(BASE_DEC)));
    plan.push_back(reg_row(REG_SIGNED_RESULT, 8'd1));
    plan.push_back(word_row(CH_MINUS));
    plan.push_back(word_row("1"));
    plan.push_back(word_row("2"));
    plan.push_back(word_row("8"));
    plan.push_back(check_row(8'h00, 1'b1, 64'hFFFF_FFFF_FFFF_FF80, ST_OK, 1'b0));
    plan.push_back(word_row("9"));
    plan.push_back(word_row("9"));
    plan.push_back(word_row("9"));
    plan.push_back(check_row(CH_SPACE, 1'b0, 64'h0000_0000_0000_007F, ST_RANGE, 1'b0));

    tx_idle_pct = 15;
    rx_idle_pct = 48;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        send_word(plan[i].word, plan[i].typed, plan[i].want);
      end
    end

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s / 5)
        0: begin tx_idle_pct = 15; rx_idle_pct = 48; end
        1: begin tx_idle_pct = 48; rx_idle_pct = 15; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      case (s)
        0: begin bm = BASE_AUTO; wl = 8'd0;   sg = 1'b1; sz = SIZE_64; end
        1: begin bm = BASE_HEX;  wl = 8'd255; sg = 1'b0; sz = SIZE_8;  end
        2: begin bm = BASE_OCT;  wl = 8'd1;   sg = 1'b0; sz = SIZE_16; end
        3: begin bm = BASE_DEC;  wl = 8'd0;   sg = 1'b1; sz = SIZE_8;  end
        default: begin
          bm = 2'($urandom_range(0, 3));
          sg = 1'($urandom_range(0, 1));
          sz = 2'($urandom_range(0, 3));
          case ($urandom_range(0, 3))
            2: wl = 8'($urandom_range(1, 6));
            3: wl = 8'($urandom_range(7, 255));
            default: wl = 8'd0;
          endcase
        end
      endcase
      drain();
      write_reg(REG_BASE_MODE, 8'(bm));
      write_reg(REG_WIDTH_LIMIT, wl);
      write_reg(REG_SIGNED_RESULT, 8'(sg));
      write_reg(REG_RESULT_SIZE, 8'(sz));

      target = words_done + RAND_ITEMS / NUM_SETTINGS;
      while (words_done < target) begin
        if ($urandom_range(0, 99) < 15) begin
          w.ch = 8'($urandom_range(0, 255));
          w.end_of_input = ($urandom_range(0, 15) == 0);
          send_word(w);
        end else begin
          send_number();
        end
      end
      // Close whatever number is still open before the registers change.
      w.ch = 8'($urandom_range(0, 255));
      w.end_of_input = 1'b1;
      send_word(w);
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
